// ===== rtl/igst_pkg.sv =====
// Shared types and constants for the IGMP snooping group table.
// Used by igst_cell and by the top level; depends on nothing else.
package igst_pkg;

    localparam int MacW = 48;
    localparam int PortW = 4;
    localparam int TimeW = 32;
    localparam int CodeW = 3;
    localparam int MaxFwd = 17;
    localparam int CntW = 5;

    localparam logic [MacW-1:0] UpnpMac = 48'h01005E7FFFFA;
    localparam logic [MacW-1:0] BcastMac = 48'hFFFFFFFFFFFF;
    localparam logic [23:0] McastOui = 24'h01005E;

    typedef enum logic [2:0] {
        OP_JOIN   = 3'd0,
        OP_V3     = 3'd1,
        OP_LEAVE  = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_TICK   = 3'd4,
        OP_DROP   = 3'd5,
        OP_CLEAR  = 3'd6,
        OP_NONE   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CL_JOIN, CL_DEL, CL_LEAVE, CL_LOOKUP, CL_TICK, CL_DROP, CL_CLEAR
    } cls_t;

    localparam logic [2:0] RtIsInclude = 3'd1;
    localparam logic [2:0] RtIsExclude = 3'd2;
    localparam logic [2:0] RtToInclude = 3'd3;
    localparam logic [2:0] RtToExclude = 3'd4;
    localparam logic [2:0] RtAllow = 3'd5;
    localparam logic [2:0] RtBlock = 3'd6;

    localparam logic [1:0] KindFwd = 2'd0;
    localparam logic [1:0] KindFlood = 2'd1;
    localparam logic [1:0] KindFinal = 2'd2;

    localparam logic [CodeW-1:0] CodeNone = 3'd0;
    localparam logic [CodeW-1:0] CodeAdded = 3'd1;
    localparam logic [CodeW-1:0] CodeRefresh = 3'd2;
    localparam logic [CodeW-1:0] CodeFull = 3'd3;
    localparam logic [CodeW-1:0] CodeDeleted = 3'd4;
    localparam logic [CodeW-1:0] CodeNotFound = 3'd5;

    // Event token that walks down the row of cells, one cell per cycle while the output does not stall.
    typedef struct packed {
        logic             act;
        cls_t             cls;
        logic             alloc;
        logic [PortW-1:0] port;
        logic [MacW-1:0]  grp;
        logic [MacW-1:0]  host;
        logic [TimeW-1:0] exp;
        logic             hit;
        logic             done;
        logic             any;
        logic [CntW-1:0]  cnt;
    } tok_t;

endpackage

// ===== rtl/igst_cell.sv =====
// One table slot of the IGMP snooping group table plus its token stage.
// Depends on igst_pkg.
module igst_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic [igst_pkg::TimeW-1:0]    tick_now,
    input  igst_pkg::tok_t                tok_i,
    output igst_pkg::tok_t                tok_o,
    output logic                          emit,
    output logic [igst_pkg::PortW-1:0]    emit_port
);
    import igst_pkg::*;

    logic             v_reg, v_next;
    logic [MacW-1:0]  g_reg, h_reg;
    logic [PortW-1:0] p_reg;
    logic [TimeW-1:0] e_reg;
    logic [TimeW-1:0] diff;
    tok_t             tok_reg, tok_next;
    logic             wr_all, wr_exp, m_grp, m_full;

    assign m_grp  = v_reg && (g_reg == tok_i.grp);
    assign m_full = m_grp && (h_reg == tok_i.host) && (p_reg == tok_i.port);
    assign diff   = tick_now - e_reg;

    always_comb begin
        tok_next  = tok_i;
        v_next    = v_reg;
        wr_all    = 1'b0;
        wr_exp    = 1'b0;
        emit      = 1'b0;
        emit_port = p_reg;
        if (tok_i.act) begin
            case (tok_i.cls)
                CL_JOIN: begin
                    if (!tok_i.alloc && m_full) begin
                        wr_exp       = 1'b1;
                        tok_next.hit = 1'b1;
                    end else if (tok_i.alloc && !v_reg && !tok_i.done) begin
                        wr_all        = 1'b1;
                        wr_exp        = 1'b1;
                        v_next        = 1'b1;
                        tok_next.done = 1'b1;
                    end
                end
                CL_DEL, CL_LEAVE: begin
                    // Only the lowest full match goes; other slots of the group survive.
                    if (m_full && !tok_i.done) begin
                        v_next        = 1'b0;
                        tok_next.done = 1'b1;
                    end else if (m_grp) begin
                        tok_next.any = 1'b1;
                    end
                end
                CL_LOOKUP: begin
                    if (m_grp) begin
                        tok_next.any = 1'b1;
                        if (tok_i.cnt < CntW'(MaxFwd)) begin
                            emit         = 1'b1;
                            tok_next.cnt = tok_i.cnt + 1'b1;
                        end
                    end
                end
                CL_TICK: begin
                    if (v_reg && diff != '0 && !diff[TimeW-1]) begin
                        v_next       = 1'b0;
                        tok_next.hit = 1'b1;
                    end
                end
                CL_DROP: begin
                    if (m_grp && p_reg == tok_i.port) begin
                        v_next       = 1'b0;
                        tok_next.hit = 1'b1;
                    end
                end
                CL_CLEAR: v_next = 1'b0;
                default: v_next = v_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg   <= 1'b0;
            tok_reg <= '0;
        end else if (adv) begin
            v_reg   <= v_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && wr_all) begin
            g_reg <= tok_i.grp;
            h_reg <= tok_i.host;
            p_reg <= tok_i.port;
        end
        if (adv && wr_exp) begin
            e_reg <= tok_i.exp;
        end
    end

    assign tok_o = tok_reg;

endmodule

// ===== rtl/igmp_snooping_group_table_unit.sv =====
// Top level of the IGMP snooping group table: APB registers, event decode,
// sequencer and a row of igst_cell slots. Depends on igst_pkg and igst_cell.
//
// Each event is decoded on its input transfer and then walked as a token down
// a row of TABLE_DEPTH cells, one slot per cycle while the output does not
// stall; a join that needs a fresh slot takes a second walk, and an event that
// needs no table access skips the walk. Forward results leave as the token
// passes member slots; the walk pauses while a result waits on the output.
// Events are handled one at a time, and s_ready is high only between events.
module igmp_snooping_group_table_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int PORT_COUNT  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_op,
    input  logic [igst_pkg::PortW-1:0]    s_port,
    input  logic [igst_pkg::MacW-1:0]     s_group_mac,
    input  logic [igst_pkg::MacW-1:0]     s_host_mac,
    input  logic [2:0]                    s_record_type,
    input  logic                          s_has_sources,
    input  logic                          s_is_ipv4,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [igst_pkg::PortW-1:0]    m_out_port,
    output logic [igst_pkg::CodeW-1:0]    m_code,
    output logic                          m_last
);
    import igst_pkg::*;

    localparam logic RegEnable = 1'b0;
    localparam logic RegTimeout = 1'b1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLOOD, ST_FINAL} state_t;

    state_t           state_reg;
    logic             en_reg;
    logic [15:0]      timeout_reg;
    logic [TimeW-1:0] tick_now_reg;
    tok_t             in_tok_reg;
    logic [CodeW-1:0] code_reg;
    logic             m_valid_reg;
    logic [1:0]       m_kind_reg;
    logic [PortW-1:0] m_port_reg;
    logic [CodeW-1:0] m_code_reg;
    logic             m_last_reg;

    tok_t             tok_chain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] emit_vec;
    logic [PortW-1:0] emit_port [TABLE_DEPTH];
    logic [PortW-1:0] fwd_port;
    logic             stall, adv, accept, cfg_wr;
    tok_t             exit_tok;
    logic [MacW-1:0]  mgrp;
    op_t              op;
    logic             bad, v3_join, v3_del;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (paddr[2] == RegTimeout) ? {16'd0, timeout_reg} : {31'd0, en_reg};

    assign stall   = m_valid_reg && !m_ready;
    assign adv     = !stall;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign op   = op_t'(s_op);
    assign mgrp = {McastOui, 1'b0, s_group_mac[22:0]};
    assign bad  = !en_reg || op == OP_NONE
                || ((op == OP_JOIN || op == OP_V3 || op == OP_LEAVE || op == OP_LOOKUP)
                    && !s_is_ipv4)
                || ((op == OP_JOIN || op == OP_V3 || op == OP_LEAVE || op == OP_DROP)
                    && int'(s_port) >= PORT_COUNT);
    assign v3_join = s_record_type == RtIsExclude || s_record_type == RtToExclude
                   || s_record_type == RtAllow
                   || ((s_record_type == RtIsInclude || s_record_type == RtToInclude)
                       && s_has_sources);
    assign v3_del  = s_record_type == RtBlock || s_record_type == RtIsInclude
                   || s_record_type == RtToInclude;

    assign tok_chain[0] = in_tok_reg;
    assign exit_tok     = tok_chain[TABLE_DEPTH];

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        igst_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .tick_now  (tick_now_reg),
            .tok_i     (tok_chain[i]),
            .tok_o     (tok_chain[i+1]),
            .emit      (emit_vec[i]),
            .emit_port (emit_port[i])
        );
    end

    always_comb begin
        fwd_port = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            fwd_port = fwd_port | (emit_port[i] & {PortW{emit_vec[i]}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg      <= 1'b0;
            timeout_reg <= 16'd260;
        end else if (cfg_wr) begin
            if (paddr[2] == RegEnable) begin
                en_reg <= pwdata[0];
            end else begin
                timeout_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_now_reg <= '0;
            in_tok_reg   <= '0;
            m_valid_reg  <= 1'b0;
            code_reg     <= CodeNone;
        end else begin
            if (adv) begin
                in_tok_reg.act <= 1'b0;
                m_valid_reg    <= 1'b0;
            end
            if (adv && |emit_vec) begin
                m_valid_reg <= 1'b1;
                m_kind_reg  <= KindFwd;
                m_port_reg  <= fwd_port;
                m_code_reg  <= CodeNone;
                m_last_reg  <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        in_tok_reg      <= '0;
                        in_tok_reg.port <= s_port;
                        in_tok_reg.host <= s_host_mac;
                        in_tok_reg.grp  <= s_group_mac;
                        in_tok_reg.exp  <= tick_now_reg + {16'd0, timeout_reg};
                        code_reg        <= CodeNone;
                        state_reg       <= ST_FINAL;
                        if (!bad) begin
                            case (op)
                                OP_JOIN: begin
                                    if (s_group_mac == UpnpMac) begin
                                        code_reg <= CodeRefresh;
                                    end else begin
                                        in_tok_reg.act <= 1'b1;
                                        in_tok_reg.cls <= CL_JOIN;
                                        state_reg      <= ST_RUN;
                                    end
                                end
                                OP_V3: begin
                                    in_tok_reg.grp <= mgrp;
                                    if (v3_join) begin
                                        if (mgrp == UpnpMac) begin
                                            code_reg <= CodeRefresh;
                                        end else begin
                                            in_tok_reg.act <= 1'b1;
                                            in_tok_reg.cls <= CL_JOIN;
                                            state_reg      <= ST_RUN;
                                        end
                                    end else if (v3_del) begin
                                        in_tok_reg.act <= 1'b1;
                                        in_tok_reg.cls <= CL_DEL;
                                        state_reg      <= ST_RUN;
                                    end
                                end
                                OP_LEAVE: begin
                                    in_tok_reg.grp <= mgrp;
                                    in_tok_reg.act <= 1'b1;
                                    in_tok_reg.cls <= CL_LEAVE;
                                    state_reg      <= ST_RUN;
                                end
                                OP_LOOKUP: begin
                                    if (s_group_mac != UpnpMac) begin
                                        in_tok_reg.act <= 1'b1;
                                        in_tok_reg.cls <= CL_LOOKUP;
                                        state_reg      <= ST_RUN;
                                    end
                                end
                                OP_TICK: begin
                                    tick_now_reg   <= tick_now_reg + 1'b1;
                                    in_tok_reg.act <= 1'b1;
                                    in_tok_reg.cls <= CL_TICK;
                                    state_reg      <= ST_RUN;
                                end
                                OP_DROP: begin
                                    in_tok_reg.act <= 1'b1;
                                    in_tok_reg.cls <= CL_DROP;
                                    state_reg      <= ST_RUN;
                                end
                                OP_CLEAR: begin
                                    in_tok_reg.act <= 1'b1;
                                    in_tok_reg.cls <= CL_CLEAR;
                                    state_reg      <= ST_RUN;
                                end
                                default: code_reg <= CodeNone;
                            endcase
                        end
                    end
                end
                ST_RUN: begin
                    if (adv && exit_tok.act) begin
                        state_reg <= ST_FINAL;
                        case (exit_tok.cls)
                            CL_JOIN: begin
                                if (!exit_tok.alloc && exit_tok.hit) begin
                                    code_reg <= CodeRefresh;
                                end else if (!exit_tok.alloc) begin
                                    // No refresh happened, so walk again to claim a free slot.
                                    in_tok_reg       <= exit_tok;
                                    in_tok_reg.alloc <= 1'b1;
                                    state_reg        <= ST_RUN;
                                end else begin
                                    code_reg <= exit_tok.done ? CodeAdded : CodeFull;
                                end
                            end
                            CL_DEL: code_reg <= exit_tok.done ? CodeDeleted : CodeNotFound;
                            CL_LEAVE: begin
                                code_reg <= exit_tok.done ? CodeDeleted : CodeNotFound;
                                if (!exit_tok.any) begin
                                    state_reg <= ST_FLOOD;
                                end
                            end
                            CL_LOOKUP: begin
                                code_reg <= (exit_tok.any || exit_tok.grp != BcastMac)
                                          ? CodeAdded : CodeNone;
                            end
                            CL_TICK: code_reg <= exit_tok.hit ? CodeDeleted : CodeAdded;
                            CL_DROP: code_reg <= exit_tok.hit ? CodeDeleted : CodeNotFound;
                            default: code_reg <= CodeAdded;
                        endcase
                    end
                end
                ST_FLOOD: begin
                    if (adv) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KindFlood;
                        m_port_reg  <= '0;
                        m_code_reg  <= CodeNone;
                        m_last_reg  <= 1'b0;
                        state_reg   <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    if (adv) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= KindFinal;
                        m_port_reg  <= '0;
                        m_code_reg  <= code_reg;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_out_port = m_port_reg;
    assign m_code     = m_code_reg;
    assign m_last     = m_last_reg;

    // Only one token is ever in the row, so at most one slot emits.
    a_one_emitter: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(emit_vec)) else $error("several slots emit at once");

    a_idle_no_token: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !in_tok_reg.act && !exit_tok.act)
        else $error("input ready while an event is in flight");

    a_tick_only_on_event: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> tick_now_reg == $past(tick_now_reg))
        else $error("time moved without an event");

endmodule

// ===== bench/tb_igmp_snooping_group_table_unit.sv =====
// Self-checking testbench for igmp_snooping_group_table_unit: a directed table
// with expected codes or mirror checks, then randomized phases checked against
// an in-bench membership table. Depends on igst_pkg and the RTL of the unit.
module tb_igmp_snooping_group_table_unit;
    import igst_pkg::*;

    localparam int Slots = 16;
    localparam logic [2:0] RegEnable = 3'd0;
    localparam logic [2:0] RegTimeout = 3'd4;
    localparam logic [2:0] RtUnusedLow = 3'd0;
    localparam logic [2:0] RtUnusedHigh = 3'd7;
    localparam logic [MacW-1:0] GrpA = 48'h01005E000101;

    typedef struct {
        op_t              op;
        logic [PortW-1:0] port;
        logic [MacW-1:0]  grp;
        logic [MacW-1:0]  host;
        logic [2:0]       rtype;
        logic             srcs;
        logic             ipv4;
    } event_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [PortW-1:0] port;
        logic [CodeW-1:0] code;
        logic             last;
    } result_t;

    typedef struct {
        event_t           ev;
        bit               typed;
        logic [CodeW-1:0] code;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic s_valid, s_ready;
    logic [2:0] s_op;
    logic [PortW-1:0] s_port;
    logic [MacW-1:0] s_group_mac, s_host_mac;
    logic [2:0] s_record_type;
    logic s_has_sources, s_is_ipv4;
    logic m_valid, m_ready;
    logic [1:0] m_kind;
    logic [PortW-1:0] m_out_port;
    logic [CodeW-1:0] m_code;
    logic m_last;

    igmp_snooping_group_table_unit dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Mirror of the membership table.
    bit               mem_valid[Slots];
    logic [MacW-1:0]  mem_grp[Slots];
    logic [MacW-1:0]  mem_host[Slots];
    logic [PortW-1:0] mem_port[Slots];
    logic [TimeW-1:0] mem_expiry[Slots];
    logic [TimeW-1:0] now_tick;
    bit               snoop_on;
    logic [15:0]      hold_ticks;

    result_t awaited[$];
    int errors = 0;
    bit idle_on = 1'b1;

    function automatic logic [CodeW-1:0] member_join(logic [MacW-1:0] g, logic [MacW-1:0] h,
                                                     logic [PortW-1:0] p);
        bit hit = 0;
        if (g == UpnpMac) return CodeRefresh;
        for (int i = 0; i < Slots; i++) begin
            if (mem_valid[i] && mem_grp[i] == g && mem_host[i] == h && mem_port[i] == p) begin
                mem_expiry[i] = now_tick + hold_ticks;
                hit = 1;
            end
        end
        if (hit) return CodeRefresh;
        for (int i = 0; i < Slots; i++) begin
            if (!mem_valid[i]) begin
                mem_valid[i] = 1;
                mem_grp[i] = g;
                mem_host[i] = h;
                mem_port[i] = p;
                mem_expiry[i] = now_tick + hold_ticks;
                return CodeAdded;
            end
        end
        return CodeFull;
    endfunction

    function automatic logic [CodeW-1:0] member_remove(logic [MacW-1:0] g, logic [MacW-1:0] h,
                                                       logic [PortW-1:0] p);
        for (int i = 0; i < Slots; i++) begin
            if (mem_valid[i] && mem_grp[i] == g && mem_host[i] == h && mem_port[i] == p) begin
                mem_valid[i] = 0;
                return CodeDeleted;
            end
        end
        return CodeNotFound;
    endfunction

    // Applies one event to the mirror and returns the results it causes.
    function automatic void apply_event(event_t ev, ref result_t res[$]);
        logic [MacW-1:0] mg = {McastOui, 1'b0, ev.grp[22:0]};
        logic [CodeW-1:0] code = CodeNone;
        logic [TimeW-1:0] age;
        bit present = 0;
        bit any = 0;
        int fwd = 0;
        res.delete();
        if (!snoop_on || ev.op == OP_NONE || (ev.op <= OP_LOOKUP && !ev.ipv4)) begin
            res.push_back({KindFinal, 4'd0, CodeNone, 1'b1});
            return;
        end
        case (ev.op)
            OP_JOIN: code = member_join(ev.grp, ev.host, ev.port);
            OP_V3: begin
                if (ev.rtype == RtIsExclude || ev.rtype == RtToExclude || ev.rtype == RtAllow ||
                    ((ev.rtype == RtIsInclude || ev.rtype == RtToInclude) && ev.srcs))
                    code = member_join(mg, ev.host, ev.port);
                else if (ev.rtype == RtBlock || ev.rtype == RtIsInclude ||
                         ev.rtype == RtToInclude)
                    code = member_remove(mg, ev.host, ev.port);
            end
            OP_LEAVE: begin
                code = member_remove(mg, ev.host, ev.port);
                for (int i = 0; i < Slots; i++)
                    if (mem_valid[i] && mem_grp[i] == mg) present = 1;
                if (!present) res.push_back({KindFlood, 4'd0, CodeNone, 1'b0});
            end
            OP_LOOKUP: begin
                if (ev.grp != UpnpMac) begin
                    for (int i = 0; i < Slots; i++) begin
                        if (mem_valid[i] && mem_grp[i] == ev.grp) begin
                            any = 1;
                            if (fwd < MaxFwd) begin
                                res.push_back({KindFwd, mem_port[i], CodeNone, 1'b0});
                                fwd++;
                            end
                        end
                    end
                    code = (any || ev.grp != BcastMac) ? CodeAdded : CodeNone;
                end
            end
            OP_TICK: begin
                now_tick = now_tick + 1;
                code = CodeAdded;
                for (int i = 0; i < Slots; i++) begin
                    if (mem_valid[i]) begin
                        age = now_tick - mem_expiry[i];
                        if (age != 0 && age < 32'h80000000) begin
                            mem_valid[i] = 0;
                            code = CodeDeleted;
                        end
                    end
                end
            end
            OP_DROP: begin
                code = CodeNotFound;
                for (int i = 0; i < Slots; i++) begin
                    if (mem_valid[i] && mem_grp[i] == ev.grp && mem_port[i] == ev.port) begin
                        mem_valid[i] = 0;
                        code = CodeDeleted;
                    end
                end
            end
            default: begin
                for (int i = 0; i < Slots; i++) mem_valid[i] = 0;
                code = CodeAdded;
            end
        endcase
        res.push_back({KindFinal, 4'd0, code, 1'b1});
    endfunction

    // Drives one event and waits for its transfer. The caller either drives the
    // next event in the same step or lowers s_valid, so valid drops between
    // back-to-back events only for the random idle gaps that this task inserts.
    task automatic send_event(event_t ev, bit typed, logic [CodeW-1:0] code);
        result_t res[$];
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= ev.op;
        s_port <= ev.port;
        s_group_mac <= ev.grp;
        s_host_mac <= ev.host;
        s_record_type <= ev.rtype;
        s_has_sources <= ev.srcs;
        s_is_ipv4 <= ev.ipv4;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_event(ev, res);
        if (typed) begin
            awaited.push_back({KindFinal, 4'd0, code, 1'b1});
        end else begin
            foreach (res[i]) awaited.push_back(res[i]);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (addr == RegEnable) snoop_on = value[0];
        else hold_ticks = value[15:0];
    endtask

    function automatic event_t mk(op_t op, logic [PortW-1:0] port, logic [MacW-1:0] grp,
                                  logic [MacW-1:0] host, logic [2:0] rtype, logic srcs,
                                  logic ipv4);
        event_t ev;
        ev.op = op;
        ev.port = port;
        ev.grp = grp;
        ev.host = host;
        ev.rtype = rtype;
        ev.srcs = srcs;
        ev.ipv4 = ipv4;
        return ev;
    endfunction

    // Small pools of groups and hosts so that joins, refreshes, deletes and
    // lookups keep hitting the same memberships.
    function automatic event_t rand_event();
        event_t ev;
        int pick = $urandom_range(0, 99);
        int g = $urandom_range(0, 99);
        if (pick < 25) ev.op = OP_JOIN;
        else if (pick < 45) ev.op = OP_V3;
        else if (pick < 57) ev.op = OP_LEAVE;
        else if (pick < 75) ev.op = OP_LOOKUP;
        else if (pick < 87) ev.op = OP_TICK;
        else if (pick < 95) ev.op = OP_DROP;
        else if (pick < 97) ev.op = OP_CLEAR;
        else ev.op = OP_NONE;
        if (g < 85) ev.grp = {McastOui, 22'd0, 2'($urandom_range(0, 3))};
        else if (g < 95) ev.grp = 48'({$urandom, $urandom});
        else if (g < 97) ev.grp = UpnpMac;
        else ev.grp = BcastMac;
        ev.host = ($urandom_range(0, 9) < 8) ? {44'h0, 4'($urandom_range(0, 3))}
                                              : 48'({$urandom, $urandom});
        ev.port = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        ev.rtype = 3'($urandom_range(0, 7));
        ev.srcs = 1'($urandom_range(0, 1));
        ev.ipv4 = $urandom_range(0, 19) != 0;
        return ev;
    endfunction

    // Result side: random stall bursts unless the quiet tail of the run is on.
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited.size() == 0) begin
                $error("unexpected result kind=%0d port=%0d code=%0d", m_kind, m_out_port,
                       m_code);
                errors++;
            end else begin
                want = awaited.pop_front();
                if (m_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_kind);
                    errors++;
                end
                if (m_out_port !== want.port) begin
                    $error("out_port: expected %0d, got %0d", want.port, m_out_port);
                    errors++;
                end
                if (m_code !== want.code) begin
                    $error("code: expected %0d, got %0d", want.code, m_code);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL igmp_snooping_group_table_unit");
        $finish;
    end

    initial begin : stimulus
        row_t rows[$];
        logic [MacW-1:0] ones = BcastMac;
        logic [MacW-1:0] h1 = 48'h0000000000A1;
        logic [MacW-1:0] h2 = 48'h0000000000B2;
        logic [MacW-1:0] folded = 48'hFFFF80000101;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= RegEnable;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_op <= OP_NONE;
        s_port <= '0;
        s_group_mac <= '0;
        s_host_mac <= '0;
        s_record_type <= '0;
        s_has_sources <= 1'b0;
        s_is_ipv4 <= 1'b0;
        m_ready <= 1'b0;
        for (int i = 0; i < Slots; i++) mem_valid[i] = 0;
        now_tick = '0;
        snoop_on = 0;
        hold_ticks = 16'd260;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{mk(OP_JOIN, 3, GrpA, h1, 0, 0, 1), 1, CodeNone});
        rows.push_back('{mk(OP_JOIN, 3, GrpA, h1, 0, 0, 1), 1, CodeAdded});
        rows.push_back('{mk(OP_JOIN, 3, GrpA, h1, 0, 0, 1), 1, CodeRefresh});
        rows.push_back('{mk(OP_JOIN, 3, UpnpMac, h1, 0, 0, 1), 1, CodeRefresh});
        rows.push_back('{mk(OP_JOIN, 3, GrpA, h1, 0, 0, 0), 1, CodeNone});
        rows.push_back('{mk(OP_NONE, 3, GrpA, h1, 0, 0, 1), 1, CodeNone});
        rows.push_back('{mk(OP_LOOKUP, 0, GrpA, 0, 0, 0, 1), 0, CodeNone});
        rows.push_back('{mk(OP_LOOKUP, 0, UpnpMac, 0, 0, 0, 1), 1, CodeNone});
        rows.push_back('{mk(OP_LOOKUP, 0, BcastMac, 0, 0, 0, 1), 1, CodeNone});
        rows.push_back('{mk(OP_LOOKUP, 0, 48'h0, 0, 0, 0, 1), 1, CodeAdded});
        // The v3 group is rebuilt from the low 23 bits, so this lands on GrpA.
        rows.push_back('{mk(OP_V3, 7, folded, h2, RtIsExclude, 0, 1), 1, CodeAdded});
        rows.push_back('{mk(OP_V3, 7, GrpA, h2, RtIsInclude, 1, 1), 1, CodeRefresh});
        rows.push_back('{mk(OP_V3, 7, GrpA, h2, RtToInclude, 0, 1), 1, CodeDeleted});
        rows.push_back('{mk(OP_V3, 7, GrpA, h2, RtIsInclude, 0, 1), 1, CodeNotFound});
        rows.push_back('{mk(OP_V3, 3, GrpA, h1, RtBlock, 1, 1), 1, CodeDeleted});
        rows.push_back('{mk(OP_V3, 3, GrpA, h1, RtUnusedLow, 1, 1), 1, CodeNone});
        rows.push_back('{mk(OP_V3, 3, GrpA, h1, RtUnusedHigh, 0, 1), 1, CodeNone});
        rows.push_back('{mk(OP_V3, 3, GrpA, h1, RtToExclude, 0, 1), 0, CodeNone});
        rows.push_back('{mk(OP_V3, 9, GrpA, h2, RtAllow, 0, 1), 0, CodeNone});
        rows.push_back('{mk(OP_LEAVE, 3, GrpA, h1, 0, 0, 1), 0, CodeNone});
        rows.push_back('{mk(OP_LEAVE, 9, GrpA, h2, 0, 0, 1), 0, CodeNone});
        rows.push_back('{mk(OP_LEAVE, 9, GrpA, h2, 0, 0, 1), 0, CodeNone});
        rows.push_back('{mk(OP_JOIN, 15, ones, ones, 7, 1, 1), 1, CodeAdded});
        rows.push_back('{mk(OP_DROP, 15, ones, 0, 0, 0, 1), 1, CodeDeleted});
        rows.push_back('{mk(OP_DROP, 15, ones, 0, 0, 0, 1), 1, CodeNotFound});
        rows.push_back('{mk(OP_TICK, 0, 0, 0, 0, 0, 0), 0, CodeNone});
        rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0), 1, CodeAdded});
        foreach (rows[r]) begin
            if (r == 1) begin
                drain();
                write_reg(RegEnable, 32'd1);
            end
            send_event(rows[r].ev, rows[r].typed, rows[r].code);
        end

        // Random phases at several register settings; the quiet one comes last.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: write_reg(RegTimeout, 32'd2);
                1: write_reg(RegTimeout, 32'd65535);
                2: write_reg(RegEnable, 32'd0);
                3: begin
                    write_reg(RegEnable, 32'd1);
                    write_reg(RegTimeout, 32'd1);
                end
                4: write_reg(RegTimeout, 32'd5);
                default: begin
                    write_reg(RegTimeout, 32'd260);
                    idle_on = 1'b0;
                end
            endcase
            // One pass of the second phase fills the table past its depth.
            if (ph == 1) begin
                for (int k = 0; k <= Slots; k++)
                    send_event(mk(OP_JOIN, 4'(k), GrpA, 48'(k + 16), 0, 0, 1), 0, CodeNone);
            end
            repeat (ph == 2 ? 15 : 40) send_event(rand_event(), 0, CodeNone);
        end
        drain();
        if (errors == 0) begin
            $display("PASS igmp_snooping_group_table_unit");
        end else begin
            $display("FAIL igmp_snooping_group_table_unit");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/igst_pkg.sv
rtl/igst_cell.sv
rtl/igmp_snooping_group_table_unit.sv
bench/tb_igmp_snooping_group_table_unit.sv
